// ===== hdl/isort_pkg.sv =====
package isort_pkg;

	typedef struct packed {
		logic signed [31:0] value;
		logic               last;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] sorted_value;
		logic               last_of_run;
		logic               overflowed;
	} out_item_t;

	typedef struct packed {
		logic insert;
		logic shift_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic one_left;
	} dp_status_t;

endpackage

// ===== hdl/isort_ctrl.sv =====
module isort_ctrl import isort_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       last,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd,
	output logic       busy
);

	typedef enum logic {
		ST_COLLECT,
		ST_EMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			case (state_q)
				ST_COLLECT: begin
					if (start && last) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// final entry leaves the store this cycle
					if (status.one_left) begin
						state_q <= ST_COLLECT;
					end
				end
				default: state_q <= ST_COLLECT;
			endcase
		end
	end

	always_comb begin
		cmd.insert    = start && (state_q == ST_COLLECT);
		cmd.shift_out = (state_q == ST_EMIT);
	end

	assign busy = (state_q == ST_EMIT);

endmodule

// ===== hdl/isort_dpath.sv =====
module isort_dpath import isort_pkg::*; #(
	parameter int DEPTH = 32,
	localparam int FW = $clog2(DEPTH + 1)
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ctrl_cmd_t  cmd,
	input  in_item_t   item,
	output out_item_t  result,
	output logic       strobe,
	output dp_status_t status
);

	logic signed [31:0] store_q [DEPTH];
	logic signed [31:0] up_v    [DEPTH];
	logic signed [31:0] dn_v    [DEPTH];
	logic [DEPTH-1:0]   gt;
	logic [DEPTH-1:0]   prev_gt;
	logic [DEPTH-1:0]   at_pos;
	logic [FW-1:0]      fill_q;
	logic               ovf_q;
	logic               strobe_q;
	logic               full;
	out_item_t          result_q;

	assign full = (fill_q == FW'(DEPTH));

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		// occupied cells holding a value above the new one move up by one
		assign gt[k] = (FW'(k) < fill_q) && (store_q[k] > item.value);

		if (k == 0) begin : g_head
			assign prev_gt[k] = 1'b0;
			assign dn_v[k]    = item.value;
		end else begin : g_body
			assign prev_gt[k] = gt[k-1];
			assign dn_v[k]    = store_q[k-1];
		end

		if (k == DEPTH - 1) begin : g_tail
			assign up_v[k] = store_q[k];
		end else begin : g_inner
			assign up_v[k] = store_q[k+1];
		end

		assign at_pos[k] = (gt[k] || (FW'(k) == fill_q)) && !prev_gt[k];

		always_ff @(posedge clk) begin
			if (cmd.shift_out) begin
				store_q[k] <= up_v[k];
			end else if (cmd.insert && !full) begin
				if (at_pos[k]) begin
					store_q[k] <= item.value;
				end else if (prev_gt[k]) begin
					store_q[k] <= dn_v[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			ovf_q    <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.shift_out;
			if (cmd.shift_out) begin
				fill_q <= fill_q - FW'(1);
				if (fill_q == FW'(1)) begin
					ovf_q <= 1'b0;
				end
			end else if (cmd.insert) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					fill_q <= fill_q + FW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift_out) begin
			result_q.sorted_value <= store_q[0];
			result_q.last_of_run  <= (fill_q == FW'(1));
			result_q.overflowed   <= ovf_q;
		end
	end

	assign result          = result_q;
	assign strobe          = strobe_q;
	assign status.one_left = (fill_q == FW'(1));

endmodule

// ===== hdl/insertion_sorter_core.sv =====
// Stable insertion sorter for signed 32-bit values. While busy is low, one item is taken
// per cycle (start high) and placed into a row of DEPTH compare-and-shift cells in that
// same cycle. An item with last set is inserted too, then busy rises and the N stored
// values come out in ascending order, one per cycle on strobe: the first result shows
// in the cycle after busy rises, the final one in the cycle busy falls. Cell 0 is
// read and the row shifts down each cycle. The final result has last_of_run set; busy is
// low during that cycle, so the next set may start there. Items beyond DEPTH are dropped
// and every result of that set shows overflowed. There is no output back-pressure:
// results must be taken when strobe is high.
module insertion_sorter_core import isort_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  item,
	output out_item_t result,
	output logic      strobe
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	isort_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (item.last),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	isort_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.result (result),
		.strobe (strobe),
		.status (status)
	);

endmodule

// ===== hdl/isort_check.sv =====
module isort_check import isort_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input in_item_t  item,
	input out_item_t result,
	input logic      strobe
);

	// a set's closing item starts the drain
	a_last_starts_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.last) |=> busy)
		else $error("closing item did not raise busy");

	a_drain_ends_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (strobe && result.last_of_run))
		else $error("drain ended without a final result");

	a_more_pending_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.last_of_run) |-> busy)
		else $error("result without final mark while not busy");

	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result outside a drain");

endmodule

bind insertion_sorter_core isort_check u_isort_check (.*);
